@@ hdl/assert_macros.svh @@
// Assertion helper macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/b64d_pkg.sv @@
// Shared widths, symbol codes and decode tables for the base64 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int CHAR_W = 8;
  localparam int SYM_W  = 6;
  localparam int PHASE_W = 2;

  // lookup result: bit 6 set means the character is not in the alphabet
  localparam logic [SYM_W:0] SYM_NONE = 7'h40;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;  // '/'

  localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PH_THIRD  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FOURTH = 2'd3;

  // alternate (permuted) alphabet, indexed by the low 7 bits of the character
  localparam logic [SYM_W:0] ALT_DECODE [0:127] = '{
    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, SYM_NONE, SYM_NONE, 7'd62,    SYM_NONE, SYM_NONE, SYM_NONE, 7'd63,
    7'd13,    7'd53,    7'd14,    7'd16,    7'd5,     7'd57,    7'd18,    7'd59,
    7'd9,     7'd55,    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, 7'd40,    7'd15,    7'd27,    7'd44,    7'd6,     7'd56,    7'd4,
    7'd47,    7'd20,    7'd60,    7'd32,    7'd50,    7'd29,    7'd52,    7'd54,
    7'd1,     7'd61,    7'd42,    7'd58,    7'd31,    7'd8,     7'd21,    7'd22,
    7'd23,    7'd24,    7'd25,    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE,
    SYM_NONE, 7'd26,    7'd2,     7'd28,    7'd12,    7'd30,    7'd19,    7'd10,
    7'd33,    7'd49,    7'd39,    7'd48,    7'd51,    7'd38,    7'd35,    7'd0,
    7'd41,    7'd17,    7'd43,    7'd3,     7'd45,    7'd46,    7'd7,     7'd36,
    7'd34,    7'd11,    7'd37,    SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE, SYM_NONE
  };

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [SYM_W:0] std_lookup(input logic [CHAR_W-1:0] c);
    logic [SYM_W:0] v;
    v = SYM_NONE;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == CHAR_PLUS) v = 7'd62;
    else if (c == CHAR_SLASH) v = 7'd63;
    return v;
  endfunction

  // symbol value of a character under the selected alphabet
  function automatic logic [SYM_W:0] sym_lookup(input logic [CHAR_W-1:0] c,
                                                input logic alt);
    logic [SYM_W:0] v;
    if (!alt) v = std_lookup(c);
    else if (c[CHAR_W-1]) v = SYM_NONE;
    else v = ALT_DECODE[c[CHAR_W-2:0]];
    return v;
  endfunction

endpackage

@@ hdl/base64_stream_decoder_top.sv @@
// Base64 stream decoder: one character in, at most one decoded byte out.
// Depends on b64d_pkg.
//
// Usage:
//   Input channel in_*: one character per item (in_text_char) with in_last_char
//   marking the final character of a message. Accepted when in_valid is high
//   and in_stall is low.
//   Result channel out_*: one result per character that yields a byte or is the
//   last one (end_of_message, with status 1 on a pad after a lone symbol).
//   Characters that produce neither give no result.
//   Config channel cfg_*: alphabet select, written when cfg_valid is high
//   (cfg_ready is always high); change it only while the block is idle.
// The result is registered: an accepted input item waits in the input register,
// then is decoded into the result register when it moves forward.
// Throughput: one item per cycle while the receiver does not stall, set by the
// combinational table lookup and bit merge.
// Reset (rst_n low, synchronous) empties both registers and clears the
// decode state and the alphabet select. When the receiver stalls, the result
// register holds and so does the item in the input register, with or without
// a result; in_stall is high while that held input item cannot move forward.
`timescale 1ns / 1ps

module base64_stream_decoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [b64d_pkg::CHAR_W-1:0]  in_text_char,
  input  logic                         in_last_char,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [b64d_pkg::CHAR_W-1:0]  out_data_byte,
  output logic                         out_byte_valid,
  output logic                         out_end_of_message,
  output logic                         out_status,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_alphabet_select
);
  import b64d_pkg::*;

  // input register
  logic                s1_valid_r;
  logic [CHAR_W-1:0]   s1_char_r;
  logic                s1_last_r;

  // decode state
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [SYM_W-1:0]    pend_r, pend_nxt;
  logic                stopped_r, stopped_nxt;
  logic                pad_err_r, pad_err_nxt;
  logic                alt_r;

  // result register
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_byte_r;
  logic                out_bvalid_r;
  logic                out_eom_r;
  logic                out_status_r;

  logic                advance;
  logic                in_take;
  logic                out_free;
  logic [CHAR_W-1:0]   ch;
  logic [SYM_W:0]      sym;
  logic                have_byte;
  logic [CHAR_W-1:0]   byte_val;
  logic                emit;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // symbol lookup; a space reads as '+'
  assign ch  = (s1_char_r == CHAR_SPACE) ? CHAR_PLUS : s1_char_r;
  assign sym = sym_lookup(ch, alt_r);

  // decode step for the item in the input register
  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    stopped_nxt = stopped_r;
    pad_err_nxt = pad_err_r;
    have_byte   = 1'b0;
    byte_val    = '0;
    if (!stopped_r) begin
      if (s1_char_r == CHAR_NUL || s1_char_r == CHAR_PAD) begin
        stopped_nxt = 1'b1;
        if (s1_char_r == CHAR_PAD && phase_r == PH_SECOND) pad_err_nxt = 1'b1;
      end else if (!sym[SYM_W]) begin
        unique case (phase_r)
          PH_FIRST: begin
            pend_nxt = sym[SYM_W-1:0];
          end
          PH_SECOND: begin
            byte_val  = {pend_r[5:0], sym[5:4]};
            pend_nxt  = {2'b00, sym[3:0]};
            have_byte = 1'b1;
          end
          PH_THIRD: begin
            byte_val  = {pend_r[3:0], sym[5:2]};
            pend_nxt  = {4'b0000, sym[1:0]};
            have_byte = 1'b1;
          end
          PH_FOURTH: begin
            byte_val  = {pend_r[1:0], sym[5:0]};
            pend_nxt  = '0;
            have_byte = 1'b1;
          end
        endcase
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  assign emit = have_byte || s1_last_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_text_char;
      s1_last_r <= in_last_char;
    end
  end

  // decode state; the last character returns everything to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      pend_r    <= '0;
      stopped_r <= 1'b0;
      pad_err_r <= 1'b0;
    end else if (advance) begin
      if (s1_last_r) begin
        phase_r   <= PH_FIRST;
        pend_r    <= '0;
        stopped_r <= 1'b0;
        pad_err_r <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pend_r    <= pend_nxt;
        stopped_r <= stopped_nxt;
        pad_err_r <= pad_err_nxt;
      end
    end
  end

  // alphabet select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      alt_r <= cfg_alphabet_select;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && emit) begin
      out_byte_r   <= byte_val;
      out_bvalid_r <= have_byte;
      out_eom_r    <= s1_last_r;
      out_status_r <= s1_last_r && pad_err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_byte_r;
  assign out_byte_valid     = out_bvalid_r;
  assign out_end_of_message = out_eom_r;
  assign out_status         = out_status_r;

endmodule

@@ hdl/b64d_checker.sv @@
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [b64d_pkg::CHAR_W-1:0]  out_data_byte,
  input logic                         out_byte_valid,
  input logic                         out_end_of_message,
  input logic                         out_status
);
  import b64d_pkg::*;

  logic [CHAR_W-1:0] zero_byte;
  assign zero_byte = '0;

  // every result carries a byte or ends a message
  `B64D_ASSERT_SAME(a_result_has_purpose, clk, rst_n,
    out_valid && !out_byte_valid, out_end_of_message, "empty result item")

  // an error status only ever comes with the end of a message
  `B64D_ASSERT_SAME(a_status_only_at_end, clk, rst_n,
    out_valid && !out_end_of_message, !out_status, "status outside end item")

  // a result without a byte shows a zero byte
  `B64D_ASSERT_SAME(a_no_byte_is_zero, clk, rst_n,
    out_valid && !out_byte_valid, out_data_byte == zero_byte,
    "nonzero byte on end-only item")

  // a stalled result stays put
  `B64D_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && out_stall, out_valid && $stable(out_data_byte) &&
    $stable(out_end_of_message), "stalled result changed")

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
